// ----- rtl/spv_pkg.sv -----
// spv_pkg: shared types, widths and codes for the spherical polygon point test
// no dependencies; imported by every module of the block except spv_ram

package spv_pkg;

   // fixed field widths
   localparam int unsigned COORD_BITS       = 16;
   localparam int unsigned INDEX_BITS       = 6;
   localparam int unsigned COUNT_BITS       = 7;
   localparam int unsigned TOL_BITS         = 41;
   localparam int unsigned CSR_INDEX_BITS   = 1;
   localparam int unsigned CSR_DATA_BITS    = 41;
   localparam int unsigned MAX_VERTICES_DEF = 64;
   localparam int unsigned COUNT_RESET      = 3;

   // datapath widths of the shared multiply-accumulate unit
   localparam int unsigned CROSS_BITS = 2 * COORD_BITS + 1;
   localparam int unsigned PROD_BITS  = CROSS_BITS + COORD_BITS;
   localparam int unsigned SUM_BITS   = PROD_BITS + 2;

   // request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TEST  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE    = 1'b1;

   // one stored vertex or one query point
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } vertex_type;

   // accumulator operations
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_CROSS_LOAD,
      ACC_CROSS_SUB,
      ACC_TOTAL_TOL,
      ACC_TOTAL_ADD
   } acc_op_type;

   // command from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic                         mul_en;
      logic                         use_cross;
      logic signed [COORD_BITS-1:0] a;
      logic signed [COORD_BITS-1:0] b;
      acc_op_type                   op;
   } mac_cmd_type;

   // finished test result handed to the output register
   typedef struct packed {
      logic valid;
      logic in_poly;
   } result_type;

   // sequencer states
   typedef enum logic [2:0] {
      CS_IDLE,
      CS_RD0,
      CS_LD0,
      CS_LDK,
      CS_EDGE,
      CS_CHECK,
      CS_DONE
   } ctrl_state_type;

   // steps of one edge evaluation
   typedef enum logic [3:0] {
      ST_CX_A,
      ST_CX_B,
      ST_CX_SUB,
      ST_PX,
      ST_CY_A,
      ST_CY_B,
      ST_CY_SUB,
      ST_PY,
      ST_CZ_A,
      ST_CZ_B,
      ST_CZ_SUB,
      ST_PZ,
      ST_SUM
   } edge_step_type;

endpackage

// ----- rtl/spv_ram.sv -----
// spv_ram: generic single-write, single-read memory with registered read data
// no dependencies

module spv_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/spv_mac.sv -----
// spv_mac: shared multiplier with one add/subtract unit and two accumulators
// depends on spv_pkg

module spv_mac (
   input  logic                         clock,
   input  spv_pkg::mac_cmd_type         cmd,
   input  logic [spv_pkg::TOL_BITS-1:0] tolerance,
   output logic                         total_neg
);
   import spv_pkg::*;

   logic signed [CROSS_BITS-1:0] mul_a;
   logic signed [COORD_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [CROSS_BITS-1:0] cross_ff, cross_in;
   logic signed [SUM_BITS-1:0]   total_ff, total_in;
   logic signed [SUM_BITS-1:0]   add_lhs, add_rhs, add_res;
   logic                         add_sub;

   // multiplier operands: a coordinate pair, or a finished cross component
   always_comb begin
      mul_a   = cmd.use_cross ? cross_ff
                : {{(CROSS_BITS-COORD_BITS){cmd.a[COORD_BITS-1]}}, cmd.a};
      mul_b   = cmd.b;
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   // single add/subtract unit shared by both accumulators
   always_comb begin
      add_rhs = {{(SUM_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
      add_sub = 1'b0;
      unique case (cmd.op)
         ACC_CROSS_LOAD: add_lhs = '0;
         ACC_CROSS_SUB: begin
            add_lhs = {{(SUM_BITS-CROSS_BITS){cross_ff[CROSS_BITS-1]}}, cross_ff};
            add_sub = 1'b1;
         end
         ACC_TOTAL_TOL: add_lhs = {{(SUM_BITS-TOL_BITS){1'b0}}, tolerance};
         ACC_TOTAL_ADD: add_lhs = total_ff;
         default:       add_lhs = '0;
      endcase
      add_res  = add_sub ? (add_lhs - add_rhs) : (add_lhs + add_rhs);
      cross_in = cross_ff;
      total_in = total_ff;
      if (cmd.op == ACC_CROSS_LOAD || cmd.op == ACC_CROSS_SUB) begin
         cross_in = add_res[CROSS_BITS-1:0];
      end
      if (cmd.op == ACC_TOTAL_TOL || cmd.op == ACC_TOTAL_ADD) begin
         total_in = add_res;
      end
   end

   // product and accumulator registers
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      cross_ff <= cross_in;
      total_ff <= total_in;
   end

   assign total_neg = total_ff[SUM_BITS-1];

endmodule

// ----- rtl/spv_ctrl.sv -----
// spv_ctrl: request handshake, vertex table access and per-edge step sequencer
// depends on spv_pkg; drives spv_mac and spv_ram through the top level

module spv_ctrl #(
   parameter int unsigned MAX_VERTICES = spv_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [spv_pkg::INDEX_BITS-1:0]    req_vertex_index,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_z_coord,
   input  logic [spv_pkg::COUNT_BITS-1:0]    vertex_count,
   output logic                              ram_wr_en,
   output logic [$clog2(MAX_VERTICES)-1:0]   ram_wr_addr,
   output spv_pkg::vertex_type               ram_wr_data,
   output logic [$clog2(MAX_VERTICES)-1:0]   ram_rd_addr,
   input  spv_pkg::vertex_type               ram_rd_data,
   output spv_pkg::mac_cmd_type              mac_cmd,
   input  logic                              total_neg,
   input  logic                              out_free,
   output spv_pkg::result_type               result
);
   import spv_pkg::*;

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

   ctrl_state_type state_ff, state_in;
   edge_step_type  step_ff, step_in;
   vertex_type     p_ff, p_in;
   vertex_type     vj_ff, vj_in;
   vertex_type     vk_ff, vk_in;
   logic [AW-1:0]  j_ff, j_in;
   logic [NW-1:0]  n_ff, n_in;
   logic           pass_ff, pass_in;
   logic           accept;
   logic [NW-1:0]  jp1, jp2;
   logic           last_edge;

   // edge index arithmetic with wrap to vertex zero
   always_comb begin
      jp1       = NW'(j_ff) + NW'(1);
      jp2       = jp1 + NW'(1);
      last_edge = (jp1 == n_ff);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != CS_IDLE);

   // vertex writes go straight into the table
   always_comb begin
      ram_wr_en   = accept && (req_action == ACT_WRITE)
                    && (32'(req_vertex_index) < MAX_VERTICES);
      ram_wr_addr = AW'(req_vertex_index);
      ram_wr_data = '{x: req_x_coord, y: req_y_coord, z: req_z_coord};
   end

   // next state, datapath registers and unit commands
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      p_in           = p_ff;
      vj_in          = vj_ff;
      vk_in          = vk_ff;
      j_in           = j_ff;
      n_in           = n_ff;
      pass_in        = pass_ff;
      ram_rd_addr    = '0;
      mac_cmd        = '{mul_en: 1'b0, use_cross: 1'b0, a: '0, b: '0, op: ACC_NONE};
      result.valid   = 1'b0;
      result.in_poly = pass_ff;

      unique case (state_ff)
         CS_IDLE: begin
            if (accept && req_action == ACT_TEST) begin
               p_in = '{x: req_x_coord, y: req_y_coord, z: req_z_coord};
               j_in = '0;
               if (32'(vertex_count) > MAX_VERTICES) begin
                  n_in = NW'(MAX_VERTICES);
               end else begin
                  n_in = NW'(vertex_count);
               end
               // no edges at all: trivially inside
               if (vertex_count == '0) begin
                  pass_in  = 1'b1;
                  state_in = CS_DONE;
               end else begin
                  state_in = CS_RD0;
               end
            end
         end

         CS_RD0: begin
            ram_rd_addr = '0;
            state_in    = CS_LD0;
         end

         CS_LD0: begin
            vj_in       = ram_rd_data;
            ram_rd_addr = last_edge ? '0 : AW'(jp1);
            state_in    = CS_LDK;
         end

         CS_LDK: begin
            vk_in    = ram_rd_data;
            step_in  = ST_CX_A;
            state_in = CS_EDGE;
         end

         CS_EDGE: begin
            step_in = edge_step_type'(step_ff + 4'd1);
            unique case (step_ff)
               ST_CX_A: mac_cmd = '{1'b1, 1'b0, vj_ff.y, vk_ff.z, ACC_NONE};
               ST_CX_B: mac_cmd = '{1'b1, 1'b0, vk_ff.y, vj_ff.z, ACC_CROSS_LOAD};
               ST_CX_SUB: mac_cmd = '{1'b0, 1'b0, '0, '0, ACC_CROSS_SUB};
               ST_PX: mac_cmd = '{1'b1, 1'b1, '0, p_ff.x, ACC_NONE};
               ST_CY_A: mac_cmd = '{1'b1, 1'b0, vj_ff.z, vk_ff.x, ACC_TOTAL_TOL};
               ST_CY_B: mac_cmd = '{1'b1, 1'b0, vk_ff.z, vj_ff.x, ACC_CROSS_LOAD};
               ST_CY_SUB: mac_cmd = '{1'b0, 1'b0, '0, '0, ACC_CROSS_SUB};
               ST_PY: mac_cmd = '{1'b1, 1'b1, '0, p_ff.y, ACC_NONE};
               ST_CZ_A: mac_cmd = '{1'b1, 1'b0, vj_ff.x, vk_ff.y, ACC_TOTAL_ADD};
               ST_CZ_B: mac_cmd = '{1'b1, 1'b0, vk_ff.x, vj_ff.y, ACC_CROSS_LOAD};
               ST_CZ_SUB: mac_cmd = '{1'b0, 1'b0, '0, '0, ACC_CROSS_SUB};
               ST_PZ: mac_cmd = '{1'b1, 1'b1, '0, p_ff.z, ACC_NONE};
               ST_SUM: begin
                  mac_cmd  = '{1'b0, 1'b0, '0, '0, ACC_TOTAL_ADD};
                  state_in = CS_CHECK;
               end
               default: state_in = CS_CHECK;
            endcase
         end

         CS_CHECK: begin
            // first failing edge ends the test
            if (total_neg) begin
               pass_in  = 1'b0;
               state_in = CS_DONE;
            end else if (last_edge) begin
               pass_in  = 1'b1;
               state_in = CS_DONE;
            end else begin
               vj_in       = vk_ff;
               j_in        = AW'(jp1);
               ram_rd_addr = (jp2 == n_ff) ? '0 : AW'(jp2);
               state_in    = CS_LDK;
            end
         end

         CS_DONE: begin
            if (out_free) begin
               result.valid = 1'b1;
               state_in     = CS_IDLE;
            end
         end

         default: state_in = CS_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         step_ff  <= ST_CX_A;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      vj_ff   <= vj_in;
      vk_ff   <= vk_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      pass_ff <= pass_in;
   end

endmodule

// ----- rtl/spherical_polygon_point_test.sv -----
// spherical_polygon_point_test: top level, configuration registers and result register
// depends on spv_pkg, spv_ram, spv_mac and spv_ctrl
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, vertex_index, x/y/z_coord
//   rsp      out        rsp_valid/rsp_stall  inside_res
//   csr      in         csr_we               csr_index, csr_wdata
//
// a vertex write is taken without a stall; the block is ready again the next cycle
// a point test reads vertex zero, then for each edge evaluated (at most the vertex
// count, capped at MAX_VERTICES) does one table read, the 13 steps on the shared
// multiplier and adder and one check; a vertex count of zero goes straight to the result
// reset is synchronous; the vertex table has no reset and must be written first
// a finished result waits in the output register while the next transaction is taken

module spherical_polygon_point_test #(
   parameter int unsigned MAX_VERTICES = spv_pkg::MAX_VERTICES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [spv_pkg::INDEX_BITS-1:0]        req_vertex_index,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_z_coord,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_inside_res,
   input  logic                                  csr_we,
   input  logic [spv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [spv_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import spv_pkg::*;

   localparam int unsigned AW = $clog2(MAX_VERTICES);

   logic [COUNT_BITS-1:0] vertex_count_ff, vertex_count_in;
   logic [TOL_BITS-1:0]   tolerance_ff, tolerance_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_inside_ff, rsp_inside_in;
   logic                  out_free;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   vertex_type            ram_wr_data, ram_rd_data;
   mac_cmd_type           mac_cmd;
   logic                  total_neg;
   result_type            result;

   // configuration writes
   always_comb begin
      vertex_count_in = vertex_count_ff;
      tolerance_in    = tolerance_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_in = csr_wdata[COUNT_BITS-1:0];
            CSR_TOLERANCE:    tolerance_in    = csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= COUNT_BITS'(COUNT_RESET);
         tolerance_ff    <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         tolerance_ff    <= tolerance_in;
      end
   end

   // output register for the result transaction
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = result.in_poly;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // vertex table
   spv_ram #(
      .WIDTH ($bits(vertex_type)),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared multiply-accumulate unit
   spv_mac u_mac (
      .clock     (clock),
      .cmd       (mac_cmd),
      .tolerance (tolerance_ff),
      .total_neg (total_neg)
   );

   // sequencer
   spv_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_vertex_index (req_vertex_index),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .vertex_count     (vertex_count_ff),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .mac_cmd          (mac_cmd),
      .total_neg        (total_neg),
      .out_free         (out_free),
      .result           (result)
   );

endmodule

// ----- rtl/spv_checker.sv -----
// spv_checker: port-level assertions for spherical_polygon_point_test, with its bind
// depends on spv_pkg; attached to the top level by the bind below

module spv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_action,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inside_res
);
   import spv_pkg::*;

   // reset leaves the block ready with no pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res))
      else $error("stalled result changed");

   // a point test makes the block busy
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_TEST |=> req_stall)
      else $error("test transaction did not occupy the block");

   // a vertex write gives no result and leaves the block ready
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_WRITE && !rsp_valid
      |=> !rsp_valid && !req_stall)
      else $error("vertex write produced a result or stalled");

   // a new result only appears after a test was in progress
   a_result_from_test: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a test in progress");

endmodule

bind spherical_polygon_point_test spv_checker u_spv_checker (.*);

// ----- dv/spv_point_checker.sv -----
// spv_point_checker: watches the csr, req and rsp ports of the point test block,
// predicts every inside flag and compares it with what the block returns
// depends on spv_pkg

module spv_point_checker #(
   parameter int unsigned MAX_VERTICES = spv_pkg::MAX_VERTICES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [spv_pkg::INDEX_BITS-1:0]        req_vertex_index,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic signed [spv_pkg::COORD_BITS-1:0] req_z_coord,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_inside_res,
   input  logic                                  csr_we,
   input  logic [spv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [spv_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output int                                    fail_count,
   output int                                    pending_count,
   output int                                    result_count,
   output int                                    inside_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spv_pkg::*;

   // shadow copy of the block state
   vertex_type                 vertex_table [MAX_VERTICES];
   logic [COUNT_BITS-1:0]      count_reg;
   logic [TOL_BITS-1:0]        tol_reg;
   logic                       expected_inside_q [$];
   logic                       expected_bit;

   // walk every edge; the point is out as soon as one triple product drops below -tolerance
   function automatic logic compute_inside(vertex_type pt);
      int unsigned edges;
      int unsigned k;
      longint      cx;
      longint      cy;
      longint      cz;
      longint      total;
      vertex_type  a;
      vertex_type  b;
      edges = (count_reg > MAX_VERTICES) ? MAX_VERTICES : count_reg;
      for (int unsigned j = 0; j < edges; j++) begin
         k = (j + 1 == edges) ? 0 : j + 1;
         a = vertex_table[j];
         b = vertex_table[k];
         cx = longint'(a.y) * longint'(b.z) - longint'(b.y) * longint'(a.z);
         cy = longint'(a.z) * longint'(b.x) - longint'(b.z) * longint'(a.x);
         cz = longint'(a.x) * longint'(b.y) - longint'(b.x) * longint'(a.y);
         total = cx * longint'(pt.x) + cy * longint'(pt.y) + cz * longint'(pt.z)
                 + longint'(tol_reg);
         if (total < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // track config, compare results, then queue new predictions
   always @(posedge clock) begin
      if (reset) begin
         count_reg = COUNT_BITS'(COUNT_RESET);
         tol_reg = '0;
         expected_inside_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VERTEX_COUNT: count_reg = csr_wdata[COUNT_BITS-1:0];
               CSR_TOLERANCE:    tol_reg = csr_wdata[TOL_BITS-1:0];
               default: ;
            endcase
         end
         // result transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_inside_q.size() == 0) begin
               $error("inside_res: result %0d arrived with nothing expected", rsp_inside_res);
               fail_count++;
            end else begin
               expected_bit = expected_inside_q.pop_front();
               result_count++;
               if (rsp_inside_res === 1'b1) inside_count++;
               if (rsp_inside_res !== expected_bit) begin
                  $error("inside_res mismatch: expected %0d actual %0d",
                         expected_bit, rsp_inside_res);
                  fail_count++;
               end
            end
         end
         // request transaction: store a vertex or predict a test
         if (req_valid && !req_stall) begin
            if (req_action == ACT_WRITE) begin
               if (req_vertex_index < MAX_VERTICES)
                  vertex_table[req_vertex_index] = {req_x_coord, req_y_coord, req_z_coord};
            end else begin
               expected_bit = compute_inside({req_x_coord, req_y_coord, req_z_coord});
               expected_inside_q = {expected_inside_q, expected_bit};
            end
         end
      end
      pending_count = expected_inside_q.size();
   end

endmodule

// ----- dv/tb_spherical_polygon_point_test.sv -----
// tb_spherical_polygon_point_test: stimulus and verdict for the spherical polygon point test
// depends on spv_pkg, spherical_polygon_point_test and spv_point_checker

module tb_spherical_polygon_point_test;
   timeunit 1ns;
   timeprecision 1ps;
   import spv_pkg::*;

   localparam real TWO_PI        = 6.283185307179586;
   localparam int  NUM_PHASES    = 20;
   localparam int  PHASE_ITEMS   = 67;
   localparam int  SETTLE_CYCLES = 16;
   localparam int  DRAIN_CYCLES  = 1000;
   localparam logic [TOL_BITS-1:0] TOL_MAX  = {TOL_BITS{1'b1}};
   localparam logic [TOL_BITS-1:0] TOL_HALF = {1'b1, {(TOL_BITS-1){1'b0}}};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_action;
   logic [INDEX_BITS-1:0]        req_vertex_index;
   logic signed [COORD_BITS-1:0] req_x_coord;
   logic signed [COORD_BITS-1:0] req_y_coord;
   logic signed [COORD_BITS-1:0] req_z_coord;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_inside_res;
   logic                         csr_we;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_wdata;

   int  fail_count;
   int  pending_count;
   int  result_count;
   int  inside_count;
   int  trans_count;
   int  setting_count;
   bit  req_gaps = 1'b1;
   bit  rsp_gaps = 1'b1;
   int  phase_counts [NUM_PHASES] = '{3, 5, 8, 4, 64, 6, 12, 3, 127, 10,
                                      7, 65, 16, 2, 1, 0, 9, 4, 20, 3};

   spherical_polygon_point_test u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_vertex_index (req_vertex_index),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   spv_point_checker u_point_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_vertex_index (req_vertex_index),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .result_count     (result_count),
      .inside_count     (inside_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= rsp_gaps && ($urandom_range(0, 99) < 12);
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("timeout: block stopped answering");
      $display("Test completed with failures");
      $finish;
   end

   function automatic real rand_unit();
      return real'($urandom_range(0, 1000000)) / 1000000.0;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] to_q15(real v);
      int t;
      t = $rtoi(v * 32767.0);
      return t[COORD_BITS-1:0];
   endfunction

   // one request transaction, entered and left at a falling edge
   task automatic send_req(input logic act, input logic [INDEX_BITS-1:0] slot,
                           input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y,
                           input logic signed [COORD_BITS-1:0] z);
      while (req_gaps && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_vertex_index <= slot;
      req_x_coord      <= x;
      req_y_coord      <= y;
      req_z_coord      <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trans_count++;
      @(negedge clock);
   endtask

   // drain outstanding results, then let a trailing vertex write finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      setting_count++;
   endtask

   // point in a cap about the pole, about half of them inside the polygon
   task automatic send_near_point(input real alpha);
      real beta;
      real phi;
      beta = alpha * 1.5 * rand_unit();
      phi  = TWO_PI * rand_unit();
      send_req(ACT_TEST, INDEX_BITS'($urandom_range(0, 63)),
               to_q15($sin(beta) * $cos(phi)), to_q15($sin(beta) * $sin(phi)),
               to_q15($cos(beta)));
   endtask

   function automatic logic [TOL_BITS-1:0] pick_tolerance(int phase);
      case (phase % 5)
         0:       return '0;
         1:       return TOL_BITS'($urandom);
         2:       return TOL_BITS'({$urandom, $urandom});
         3:       return TOL_MAX;
         default: return TOL_HALF;
      endcase
   endfunction

   initial begin
      int   edges;
      int   pick;
      real  alpha;
      real  spin;
      real  theta;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_WRITE;
      req_vertex_index = '0;
      req_x_coord      = '0;
      req_y_coord      = '0;
      req_z_coord      = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_VERTEX_COUNT;
      csr_wdata        = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: octant triangle at reset config, extreme coordinates
      send_req(ACT_WRITE, 6'd0, 16'sd32767, 16'sd0, 16'sd0);
      send_req(ACT_WRITE, 6'd1, 16'sd0, 16'sd32767, 16'sd0);
      send_req(ACT_WRITE, 6'd2, 16'sd0, 16'sd0, 16'sd32767);
      send_req(ACT_TEST, 6'd63, 16'sd9000, 16'sd9000, 16'sd9000);
      send_req(ACT_TEST, 6'd0, -16'sd32768, -16'sd32768, -16'sd32768);
      send_req(ACT_TEST, 6'd21, 16'sd32767, 16'sd32767, 16'sd32767);
      // zero point gives zero triple products everywhere
      send_req(ACT_TEST, 6'd42, 16'sd0, 16'sd0, 16'sd0);
      send_req(ACT_TEST, 6'd5, 16'sd32767, -16'sd32768, 16'sd0);
      send_req(ACT_WRITE, 6'd63, -16'sd32768, -16'sd32768, -16'sd32768);
      send_req(ACT_WRITE, 6'd0, -16'sd32768, 16'sd32767, -16'sd32768);
      send_req(ACT_TEST, 6'd7, -16'sd1, -16'sd1, -16'sd1);
      send_req(ACT_TEST, 6'd0, 16'sd1, 16'sd0, 16'sd0);

      // no edges at all
      write_csr(CSR_VERTEX_COUNT, CSR_DATA_BITS'(0));
      send_req(ACT_TEST, 6'd0, -16'sd32768, -16'sd32768, -16'sd32768);
      // single vertex, one degenerate edge
      write_csr(CSR_VERTEX_COUNT, CSR_DATA_BITS'(1));
      send_req(ACT_TEST, 6'd1, 16'sd32767, -16'sd32768, 16'sd32767);
      // two vertices, edges back and forth
      write_csr(CSR_VERTEX_COUNT, CSR_DATA_BITS'(2));
      send_req(ACT_TEST, 6'd2, 16'sd12000, -16'sd20000, 16'sd3000);
      send_req(ACT_TEST, 6'd3, 16'sd0, 16'sd0, 16'sd0);
      // tolerance extremes
      write_csr(CSR_VERTEX_COUNT, CSR_DATA_BITS'(3));
      write_csr(CSR_TOLERANCE, CSR_DATA_BITS'(TOL_MAX));
      send_req(ACT_TEST, 6'd4, -16'sd32768, -16'sd32768, -16'sd32768);
      write_csr(CSR_TOLERANCE, CSR_DATA_BITS'(TOL_HALF));
      send_req(ACT_TEST, 6'd9, -16'sd200, 16'sd100, -16'sd300);

      // random phases: convex polygon about the pole, then mostly point tests
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_gaps <= !(phase >= 5 && phase <= 7);
         rsp_gaps <= !(phase >= 5 && phase <= 7);
         write_csr(CSR_VERTEX_COUNT, CSR_DATA_BITS'(phase_counts[phase]));
         write_csr(CSR_TOLERANCE, CSR_DATA_BITS'(pick_tolerance(phase)));
         edges = (phase_counts[phase] > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF
                                                          : phase_counts[phase];
         alpha = 0.15 + 1.1 * rand_unit();
         spin  = TWO_PI * rand_unit();
         for (int i = 0; i < edges; i++) begin
            theta = spin + TWO_PI * (real'(i) + 0.4 * rand_unit()) / real'(edges);
            send_req(ACT_WRITE, INDEX_BITS'(i),
                     to_q15($sin(alpha) * $cos(theta)), to_q15($sin(alpha) * $sin(theta)),
                     to_q15($cos(alpha)));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               send_near_point(alpha);
            end else if (pick < 88) begin
               send_req(ACT_TEST, INDEX_BITS'($urandom), COORD_BITS'($urandom),
                        COORD_BITS'($urandom), COORD_BITS'($urandom));
            end else begin
               // stray vertex, sometimes breaking the polygon
               send_req(ACT_WRITE, INDEX_BITS'($urandom), COORD_BITS'($urandom),
                        COORD_BITS'($urandom), COORD_BITS'($urandom));
            end
         end
      end

      // drain and watch for stray results
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d transactions under %0d register writes", trans_count,
               setting_count);
      $display("checked %0d inside flags, %0d of them inside", result_count, inside_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
